[design/ccr_pkg.sv]
package ccr_pkg;

	// Default build-time sizes
	localparam int SINE_TABLE_BITS = 10;
	localparam int SAMPLE_BITS     = 16;

	// Fixed formats
	localparam int GAIN_BITS  = 32;
	localparam int PHASE_BITS = 32;
	localparam int TAB_BITS   = 15;   // quarter-wave magnitude, 0..16384
	localparam int COEF_BITS  = 16;   // signed Q1.14 sine/cosine
	localparam int FRAC_BITS  = 14;
	localparam int ROUND_HALF = 8192;
	localparam int CFG_INDEX_BITS = 1;

	localparam logic [31:0] FREQ_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] FREQ_MIN = 32'h8000_0000;

	// Register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA_GAIN = 1'b0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BETA_GAIN  = 1'b1;

	// Taylor constants, Q2.30
	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic mult;
		logic rnd;
		logic gain;
		logic commit;
	} cmd_t;

	// Sine of p quarter-wave steps (0..quarter), Q1.14, capped at 1.0.
	// Only evaluated with constant arguments to build the lookup table.
	function automatic logic [TAB_BITS-1:0] quarter_sine(input int unsigned p,
		input int unsigned tb);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] m;
		logic [63:0] s;
		x  = (64'(p) * HALF_PI_Q30) >> (tb - 2);
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		for (int n = 0; n < 5; n++) begin
			m = (x2 * t) >> 30;
			case (n)
				0: t = Q30_ONE - m / 64'd110;
				1: t = Q30_ONE - m / 64'd72;
				2: t = Q30_ONE - m / 64'd42;
				3: t = Q30_ONE - m / 64'd20;
				default: t = Q30_ONE - m / 64'd6;
			endcase
		end
		s = (x * t) >> 30;
		s = (s + 64'd32768) >> 16;
		if (s > 64'd16384)
			s = 64'd16384;
		return s[TAB_BITS-1:0];
	endfunction

endpackage

[design/ccr_ctrl.sv]
module ccr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output ccr_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULT,
		ST_RND,
		ST_GAIN,
		ST_UPD
	} state_t;

	state_t state_q;
	logic   out_free;

	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	// Command decode
	always_comb begin
		cmd.capture = (state_q == ST_IDLE) && in_valid;
		cmd.mult    = (state_q == ST_MULT);
		cmd.rnd     = (state_q == ST_RND);
		cmd.gain    = (state_q == ST_GAIN);
		cmd.commit  = (state_q == ST_UPD) && out_free;
	end

	// Sequencer and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_MULT;
				end
				ST_MULT: state_q <= ST_RND;
				ST_RND:  state_q <= ST_GAIN;
				ST_GAIN: state_q <= ST_UPD;
				ST_UPD: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.commit)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

endmodule

[design/ccr_datapath.sv]
module ccr_datapath #(
	parameter int SINE_TABLE_BITS = ccr_pkg::SINE_TABLE_BITS,
	parameter int SAMPLE_BITS     = ccr_pkg::SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ccr_pkg::cmd_t                       cmd,
	input  logic                                cfg_we,
	input  logic [ccr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [ccr_pkg::GAIN_BITS-1:0]       cfg_wdata,
	input  logic signed [SAMPLE_BITS-1:0]       sample_i,
	input  logic signed [SAMPLE_BITS-1:0]       sample_q,
	output logic signed [SAMPLE_BITS-1:0]       rotated_i,
	output logic signed [SAMPLE_BITS-1:0]       rotated_q,
	output logic signed [SAMPLE_BITS:0]         phase_error
);

	localparam int TB   = SINE_TABLE_BITS;
	localparam int SB   = SAMPLE_BITS;
	localparam int CB   = ccr_pkg::COEF_BITS;
	localparam int DN   = ccr_pkg::PHASE_BITS - TB;
	localparam int QTR  = 1 << (TB - 2);
	localparam int PW   = SB + CB;              // rotation product
	localparam int GW   = ccr_pkg::GAIN_BITS + SB + 2; // gain product
	localparam int BSW  = GW - 16;              // frequency step
	localparam int FW   = ((BSW > 32) ? BSW : 32) + 1;
	localparam logic [TB-2:0] QTR_IDX = (TB - 1)'(QTR);
	localparam logic [TB-1:0] QTR_K   = TB'(QTR);

	// Quarter-wave sine table, built at elaboration
	logic [ccr_pkg::TAB_BITS-1:0] qtab [QTR+1];

	for (genvar k = 0; k <= QTR; k++) begin : g_tab
		assign qtab[k] = ccr_pkg::quarter_sine(k, TB);
	end

	// Full-wave entry from the quarter table by symmetry
	function automatic logic signed [CB-1:0] tab_value(input logic [TB-1:0] idx);
		logic [1:0]      quad;
		logic [TB-3:0]   p;
		logic [TB-2:0]   a;
		logic [CB-1:0]   v;
		quad = idx[TB-1:TB-2];
		p    = idx[TB-3:0];
		a    = quad[0] ? (QTR_IDX - {1'b0, p}) : {1'b0, p};
		v    = {1'b0, qtab[a]};
		return quad[1] ? -v : v;
	endfunction

	// Round half up by 2^14, saturate to the sample range
	function automatic logic signed [SB-1:0] sat_round(input logic signed [PW:0] v);
		logic signed [PW:0] r;
		logic [SB+2:0]      t;
		r = v + (PW + 1)'(ccr_pkg::ROUND_HALF);
		t = r[PW:ccr_pkg::FRAC_BITS];
		if (t[SB+2:SB-1] == {4{t[SB+2]}})
			return t[SB-1:0];
		else if (t[SB+2])
			return {1'b1, {(SB - 1){1'b0}}};
		else
			return {1'b0, {(SB - 1){1'b1}}};
	endfunction

	// Loop state and gains
	logic [ccr_pkg::GAIN_BITS-1:0]  alpha_q, beta_q;
	logic [ccr_pkg::PHASE_BITS-1:0] phase_q;
	logic [31:0]                    freq_q;

	// Pipeline registers
	logic signed [SB-1:0] si_q, sq_q;
	logic signed [CB-1:0] sin_q, cos_q;
	logic signed [PW-1:0] p_ic_s1, p_qs_s1, p_qc_s1, p_is_s1;
	logic signed [SB-1:0] ri_s2, rq_s2;
	logic signed [SB:0]   err_s2;
	logic signed [GW-1:0] bprod_s3, aprod_s3;

	// Combinational terms
	logic [TB-1:0]        k_sin, k_cos;
	logic signed [PW:0]   sum_i, sum_q;
	logic signed [SB-1:0] ri_c, rq_c;
	logic signed [SB+1:0] ta, tb_e, err_c;
	logic signed [BSW-1:0] bstep;
	logic signed [FW-1:0] f_sum;
	logic [31:0]          f_sat;
	logic [31:0]          phase_next;

	// Table index: phase rounded to the nearest table step
	assign k_sin = phase_q[ccr_pkg::PHASE_BITS-1:DN] + TB'(phase_q[DN-1]);
	assign k_cos = k_sin + QTR_K;

	// Derotation sums and detector
	always_comb begin
		sum_i = {p_ic_s1[PW-1], p_ic_s1} + {p_qs_s1[PW-1], p_qs_s1};
		sum_q = {p_qc_s1[PW-1], p_qc_s1} - {p_is_s1[PW-1], p_is_s1};
		ri_c  = sat_round(sum_i);
		rq_c  = sat_round(sum_q);
		ta    = ri_c[SB-1] ? -(SB + 2)'(rq_c) : (SB + 2)'(rq_c);
		tb_e  = rq_c[SB-1] ? -(SB + 2)'(ri_c) : (SB + 2)'(ri_c);
		err_c = ta - tb_e;
	end

	// Loop filter: saturating frequency, then wrapping phase
	always_comb begin
		bstep = bprod_s3[GW-1:16];
		f_sum = FW'(signed'(freq_q)) + FW'(bstep);
		if (f_sum[FW-1:31] != {(FW - 31){f_sum[FW-1]}})
			f_sat = f_sum[FW-1] ? ccr_pkg::FREQ_MIN : ccr_pkg::FREQ_MAX;
		else
			f_sat = f_sum[31:0];
		phase_next = phase_q + f_sat + 32'(aprod_s3 >>> 16);
	end

	// Configuration and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= '0;
			beta_q  <= '0;
			phase_q <= '0;
			freq_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ccr_pkg::REG_ALPHA_GAIN: alpha_q <= cfg_wdata;
					ccr_pkg::REG_BETA_GAIN:  beta_q  <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.commit) begin
				freq_q  <= f_sat;
				phase_q <= phase_next;
			end
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			si_q  <= sample_i;
			sq_q  <= sample_q;
			sin_q <= tab_value(k_sin);
			cos_q <= tab_value(k_cos);
		end
		if (cmd.mult) begin
			p_ic_s1 <= si_q * cos_q;
			p_qs_s1 <= sq_q * sin_q;
			p_qc_s1 <= sq_q * cos_q;
			p_is_s1 <= si_q * sin_q;
		end
		if (cmd.rnd) begin
			ri_s2  <= ri_c;
			rq_s2  <= rq_c;
			err_s2 <= err_c[SB:0];
		end
		if (cmd.gain) begin
			bprod_s3 <= signed'({1'b0, beta_q}) * err_s2;
			aprod_s3 <= signed'({1'b0, alpha_q}) * err_s2;
		end
		if (cmd.commit) begin
			rotated_i   <= ri_s2;
			rotated_q   <= rq_s2;
			phase_error <= err_s2;
		end
	end

endmodule

[design/costas_carrier_recovery.sv]
// QPSK Costas loop carrier recovery.
// Input stream (s_axis): one complex sample per transfer, I in the low half
// of tdata, Q above it. Output stream (m_axis): one result per input sample,
// the derotated I and Q and the detector error. Gains are set through the
// cfg port (index 0 alpha, index 1 beta); the user must write them only
// while no sample is in flight, as the block does not enforce this. A sample
// taken in idle goes through table lookup, rotation multiplies, round/detect
// and gain multiplies to the phase update, which also shows it on m_axis, so
// a new sample is taken only after that update; s_axis_tready is high only
// while the block is idle. The phase for the next sample is known only after
// the current update. When the receiver stalls, the finished result waits in
// the output register and the next sample may already be taken and worked
// on; its update and result wait until the previous result is taken.
// Reset clears phase, frequency, both gains and all valid flags.
module costas_carrier_recovery #(
	parameter int SINE_TABLE_BITS = ccr_pkg::SINE_TABLE_BITS,
	parameter int SAMPLE_BITS     = ccr_pkg::SAMPLE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	// Configuration writes
	input  logic                               cfg_we,
	input  logic [ccr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ccr_pkg::GAIN_BITS-1:0]      cfg_wdata,
	// Sample input
	input  logic                                        s_axis_tvalid,
	output logic                                        s_axis_tready,
	// tdata: sample_i, sample_q
	input  logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// Result output
	output logic                                        m_axis_tvalid,
	input  logic                                        m_axis_tready,
	// tdata: rotated_i, rotated_q, phase_error
	output logic [((3 * SAMPLE_BITS + 8) / 8) * 8 - 1:0] m_axis_tdata
);

	localparam int SB    = SAMPLE_BITS;
	localparam int OUT_W = ((3 * SB + 8) / 8) * 8;

	ccr_pkg::cmd_t        cmd;
	logic signed [SB-1:0] rot_i, rot_q;
	logic signed [SB:0]   err;

	ccr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	ccr_datapath #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.SAMPLE_BITS     (SAMPLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.sample_i    (s_axis_tdata[SB-1:0]),
		.sample_q    (s_axis_tdata[2*SB-1:SB]),
		.rotated_i   (rot_i),
		.rotated_q   (rot_q),
		.phase_error (err)
	);

	assign m_axis_tdata = OUT_W'({err, rot_q, rot_i});

endmodule

[verif/costas_carrier_recovery_tb.sv]
module costas_carrier_recovery_tb;

	localparam int SB        = ccr_pkg::SAMPLE_BITS;
	localparam int LUT_BITS  = ccr_pkg::SINE_TABLE_BITS;
	localparam int LUT_SIZE  = 1 << LUT_BITS;
	localparam int QUARTER   = LUT_SIZE / 4;
	localparam int IN_W      = ((2 * SB + 7) / 8) * 8;
	localparam int OUT_W     = ((3 * SB + 8) / 8) * 8;

	localparam longint S_MAX = (64'sd1 <<< (SB - 1)) - 1;
	localparam longint S_MIN = -(64'sd1 <<< (SB - 1));
	localparam longint F_MAX = 64'sd2147483647;
	localparam longint F_MIN = -64'sd2147483648;

	// Q2.30 constants for the quarter-wave series
	localparam bit [63:0] ONE_Q30     = 64'd1 << 30;
	localparam bit [63:0] HALF_PI_FIX = 64'd1686629713;

	localparam int SETTLE_CYCLES = 20;
	localparam int STALL_LIMIT   = 4000;
	localparam int PHASE_ITEMS   = 210;
	localparam int NUM_SETTINGS  = 8;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic signed [SB-1:0] re;
		logic signed [SB-1:0] im;
	} sample_t;

	typedef struct packed {
		logic signed [SB-1:0] rot_i;
		logic signed [SB-1:0] rot_q;
		logic signed [SB:0]   err;
	} derot_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ccr_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [ccr_pkg::GAIN_BITS-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;     // sample_i, sample_q
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;         // rotated_i, rotated_q, phase_error

	// Loop state tracked alongside the block
	int signed sine_lut [LUT_SIZE];
	logic [31:0] est_phase = '0;
	logic signed [31:0] est_freq = '0;
	logic [31:0] gain_a = '0;
	logic [31:0] gain_b = '0;

	sample_t sample_backlog [$];
	derot_t pending_derot [$];
	sample_t in_flight;
	derot_t want;
	idle_mode_t idle_mode = IDLE_NONE;

	int mismatches = 0;
	int samples_in = 0;
	int results_out = 0;
	int sat_hits = 0;
	int freq_clamps = 0;
	int zero_signs = 0;
	int stall_cycles = 0;

	costas_carrier_recovery uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Sine of a given number of quarter-wave steps, Q1.14, odd series nested from the top term
	function automatic int quarter_wave(input int unsigned step);
		bit [63:0] x;
		bit [63:0] x2;
		bit [63:0] t;
		bit [63:0] s;
		int unsigned m;
		x = (64'(step) * HALF_PI_FIX) >> (LUT_BITS - 2);
		x2 = (x * x) >> 30;
		t = ONE_Q30;
		for (int n = 0; n < 5; n++) begin
			m = 2 * (5 - n);
			t = ONE_Q30 - ((x2 * t) >> 30) / 64'(m * (m + 1));
		end
		s = (x * t) >> 30;
		s = (s + 64'd32768) >> 16;
		return (s > 64'd16384) ? 16384 : int'(s);
	endfunction

	function automatic logic signed [SB-1:0] saturate(input longint v);
		if (v > S_MAX)
			v = S_MAX;
		else if (v < S_MIN)
			v = S_MIN;
		return v[SB-1:0];
	endfunction

	// Round half up out of Q1.14, then clip
	function automatic logic signed [SB-1:0] round_clip(input longint v);
		longint r;
		r = (v + 64'sd8192) >>> 14;
		if (r > S_MAX || r < S_MIN)
			sat_hits++;
		return saturate(r);
	endfunction

	// Derotate one sample by the current phase and advance the PI loop
	function automatic derot_t derotate_step(input sample_t smp);
		derot_t res;
		logic [32:0] ph_round;
		logic [LUT_BITS-1:0] k;
		longint c, s, si, sq, ri, rq, e, f, step;
		ph_round = {1'b0, est_phase} + (33'd1 << (31 - LUT_BITS));
		k = ph_round[31 -: LUT_BITS];
		s = sine_lut[k];
		c = sine_lut[(int'(k) + QUARTER) % LUT_SIZE];
		si = smp.re;
		sq = smp.im;
		ri = round_clip(si * c + sq * s);
		rq = round_clip(sq * c - si * s);
		if (ri == 0 || rq == 0)
			zero_signs++;
		// zero counts as positive in the slicer
		e = ((ri >= 0) ? rq : -rq) - ((rq >= 0) ? ri : -ri);
		f = longint'(est_freq) + ((longint'(gain_b) * e) >>> 16);
		if (f > F_MAX) begin
			f = F_MAX;
			freq_clamps++;
		end else if (f < F_MIN) begin
			f = F_MIN;
			freq_clamps++;
		end
		est_freq = f[31:0];
		step = f + ((longint'(gain_a) * e) >>> 16);
		est_phase = est_phase + step[31:0];
		res.rot_i = ri[SB-1:0];
		res.rot_q = rq[SB-1:0];
		res.err = e[SB:0];
		return res;
	endfunction

	// QPSK point of the given amplitude with random signs, turned by a carrier angle, plus noise
	function automatic sample_t qpsk_symbol(input int amp, input int noise,
		input logic [LUT_BITS-1:0] rot);
		sample_t smp;
		longint a_i, a_q, c, s, n_i, n_q;
		a_i = $urandom_range(0, 1) ? amp : -amp;
		a_q = $urandom_range(0, 1) ? amp : -amp;
		s = sine_lut[rot];
		c = sine_lut[(int'(rot) + QUARTER) % LUT_SIZE];
		n_i = longint'($urandom_range(0, 2 * noise)) - noise;
		n_q = longint'($urandom_range(0, 2 * noise)) - noise;
		smp.re = saturate(((a_i * c - a_q * s) >>> 14) + n_i);
		smp.im = saturate(((a_i * s + a_q * c) >>> 14) + n_q);
		return smp;
	endfunction

	function automatic logic signed [SB-1:0] corner_value();
		case ($urandom_range(0, 7))
			0: return saturate(S_MIN);
			1: return saturate(S_MIN + 1);
			2: return saturate(-16384);
			3: return saturate(-1);
			4: return saturate(0);
			5: return saturate(1);
			6: return saturate(16384);
			default: return saturate(S_MAX);
		endcase
	endfunction

	// Random back-pressure or gaps, by idle pattern and side
	function automatic bit takes_pause(input bit recv_side);
		case (idle_mode)
			IDLE_SEND: return !recv_side && ($urandom_range(0, 99) < 76);
			IDLE_RECV: return recv_side && ($urandom_range(0, 99) < 76);
			IDLE_BOTH: return $urandom_range(0, 99) < 23;
			default: return 1'b0;
		endcase
	endfunction

	task automatic queue_sample(input longint re, input longint im);
		sample_t smp;
		smp.re = saturate(re);
		smp.im = saturate(im);
		sample_backlog = {sample_backlog, smp};
	endtask

	task automatic write_gain(input logic [ccr_pkg::CFG_INDEX_BITS-1:0] idx,
		input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == ccr_pkg::REG_ALPHA_GAIN)
			gain_a = val;
		else
			gain_b = val;
	endtask

	// Settle on a falling edge once nothing is queued, driven or owed
	task automatic wait_drained();
		do
			@(negedge clk);
		while (sample_backlog.size() != 0 || s_axis_tvalid || pending_derot.size() != 0);
	endtask

	task automatic flag_mismatch(input string what, input longint got, input longint exp_val);
		mismatches++;
		$display("[%0t] result %0d: %s got %0d, expected %0d",
			$time, results_out, what, got, exp_val);
	endtask

	// Sample driver: predict on each transfer, then offer the next sample
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				pending_derot = {pending_derot, derotate_step(in_flight)};
				samples_in++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (sample_backlog.size() != 0 && !takes_pause(1'b0)) begin
					in_flight = sample_backlog.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= IN_W'({in_flight.im, in_flight.re});
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_out++;
				if (pending_derot.size() == 0) begin
					flag_mismatch("result with nothing pending", 1, 0);
				end else begin
					want = pending_derot.pop_front();
					if (m_axis_tdata[SB-1:0] !== want.rot_i)
						flag_mismatch("rotated_i", longint'($signed(m_axis_tdata[SB-1:0])),
							longint'(want.rot_i));
					if (m_axis_tdata[2*SB-1:SB] !== want.rot_q)
						flag_mismatch("rotated_q", longint'($signed(m_axis_tdata[2*SB-1:SB])),
							longint'(want.rot_q));
					if (m_axis_tdata[3*SB:2*SB] !== want.err)
						flag_mismatch("phase_error", longint'($signed(m_axis_tdata[3*SB:2*SB])),
							longint'(want.err));
					if (m_axis_tdata[OUT_W-1:3*SB+1] !== '0)
						flag_mismatch("tdata padding", longint'(m_axis_tdata[OUT_W-1:3*SB+1]), 0);
				end
			end
			m_axis_tready <= !takes_pause(1'b1);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
			stall_cycles = 0;
		end else begin
			stall_cycles = stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		int unsigned p;
		int quad;
		int v;
		int pick;
		int amp;
		int carrier_step;
		logic [31:0] carrier;
		logic [31:0] a_set;
		logic [31:0] b_set;
		sample_t smp;

		// Full-turn sine table from quarter-wave symmetry
		for (int k = 0; k < LUT_SIZE; k++) begin
			quad = k / QUARTER;
			p = k % QUARTER;
			v = (quad % 2 != 0) ? quarter_wave(QUARTER - p) : quarter_wave(p);
			sine_lut[k] = (quad >= 2) ? -v : v;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Gains at reset: phase holds at zero, field extremes and zero signs
		@(negedge clk);
		queue_sample(S_MAX, S_MAX);
		queue_sample(S_MIN, S_MIN);
		queue_sample(0, 0);
		queue_sample(0, -1);
		queue_sample(-1, 0);
		queue_sample(S_MAX, S_MIN);
		queue_sample(S_MIN, S_MAX);
		queue_sample(1, -1);
		queue_sample(16384, 0);
		queue_sample(0, -16384);
		wait_drained();

		// Full-scale gains: frequency clamps, phase wraps, outputs clip off-axis
		write_gain(ccr_pkg::REG_ALPHA_GAIN, '1);
		write_gain(ccr_pkg::REG_BETA_GAIN, '1);
		@(negedge clk);
		queue_sample(S_MAX, 0);
		queue_sample(S_MAX, S_MAX);
		queue_sample(S_MIN, S_MAX);
		queue_sample(0, S_MIN);
		queue_sample(-1, -1);
		queue_sample(S_MIN, S_MIN);
		queue_sample(12000, -12000);
		queue_sample(S_MAX, S_MIN);
		queue_sample(-5, 3);
		queue_sample(S_MAX, 1);

		// Random phases, one gain setting and idle pattern each
		for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
			wait_drained();
			case (setting)
				0: begin a_set = '0; b_set = '0; end
				1, 6: begin
					a_set = $urandom_range(1 << 16, 1 << 22);
					b_set = $urandom_range(1 << 8, 1 << 14);
				end
				2: begin a_set = '1; b_set = '1; end
				3: begin a_set = $urandom; b_set = $urandom; end
				4: begin a_set = '1; b_set = '0; end
				5: begin a_set = '0; b_set = '1; end
				default: begin a_set = 32'd1; b_set = 32'd1; end
			endcase
			write_gain(ccr_pkg::REG_ALPHA_GAIN, a_set);
			write_gain(ccr_pkg::REG_BETA_GAIN, b_set);
			idle_mode = idle_mode_t'(setting % 4);
			carrier = $urandom;
			carrier_step = ($urandom_range(0, 3) == 0) ? 0 :
				int'($urandom_range(0, 1 << 25)) - (1 << 24);
			@(negedge clk);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				carrier = carrier + carrier_step;
				if (pick < 65) begin
					amp = ($urandom_range(0, 9) == 0) ? $urandom_range(16384, 32767) :
						$urandom_range(1000, 16000);
					smp = qpsk_symbol(amp, $urandom_range(0, 2000), carrier[31 -: LUT_BITS]);
				end else if (pick < 85) begin
					smp.re = SB'($urandom);
					smp.im = SB'($urandom);
				end else begin
					smp.re = corner_value();
					smp.im = ($urandom_range(0, 1) != 0) ? corner_value() : SB'($urandom);
				end
				sample_backlog = {sample_backlog, smp};
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d samples through %0d gain settings and four idle patterns, %0d results checked",
			samples_in, NUM_SETTINGS + 2, results_out);
		$display("Seen: %0d clipped outputs, %0d frequency clamps, %0d zero slicer inputs",
			sat_hits, freq_clamps, zero_signs);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
